>>> rtl/byte_pipe_fifo_with_close_assert.svh
// Assertion macros used by the checker file of the byte pipe.
`ifndef BYTE_PIPE_FIFO_WITH_CLOSE_ASSERT_SVH
`define BYTE_PIPE_FIFO_WITH_CLOSE_ASSERT_SVH

// Property checked on every rising edge of clk, ignored while rst_n is low.
`define BPFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define BPFC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/bpfc_pkg.sv
// Shared constants, codes and control types of the byte pipe.
package bpfc_pkg;

  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;
  localparam int AW       = $clog2(DEPTH);
  localparam int LEVEL_W  = 13;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 8;

  typedef enum logic [1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_READ     = 2'd1,
    FUNC_CLOSE_RD = 2'd2,
    FUNC_CLOSE_WR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EOF    = 2'd1,
    ST_BLOCK  = 2'd2,
    ST_BROKEN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    END_OPEN      = 2'd0,
    END_RD_CLOSED = 2'd1,
    END_WR_CLOSED = 2'd2,
    END_CLOSED    = 2'd3
  } end_state_t;

  typedef struct packed {
    logic latch;
    logic single;
    logic start_rd;
    logic push_byte;
    logic cont_rd;
  } cmd_t;

  typedef struct packed {
    logic burst;
    logic out_free;
    logic rd_last;
  } sts_t;

endpackage

>>> rtl/bpfc_ctrl.sv
// Controller state machine of the byte pipe.
module bpfc_ctrl
  import bpfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD_DATA
  } state_t;

  state_t state_r;
  logic   in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch = in_valid;
      end
      S_EXEC: begin
        cmd.start_rd = sts.burst;
        cmd.single   = !sts.burst && sts.out_free;
      end
      S_RD_DATA: begin
        cmd.push_byte = sts.out_free;
        cmd.cont_rd   = sts.out_free && !sts.rd_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_EXEC;
            in_stall_r <= 1'b1;
          end
        end
        S_EXEC: begin
          if (sts.burst) begin
            state_r <= S_RD_DATA;
          end else if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        S_RD_DATA: begin
          if (sts.out_free && sts.rd_last) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_stall_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/bpfc_dp.sv
// Datapath of the byte pipe: byte store, pointers, end state and output register.
module bpfc_dp
  import bpfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_func,
  input  logic [DATA_W-1:0]  in_wr_data,
  input  logic [CNT_W-1:0]   in_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [DATA_W-1:0]  out_rd_data,
  output logic               out_data_valid,
  output logic               out_last,
  output logic [LEVEL_W-1:0] out_level,
  output logic               out_can_free
);

  logic [DATA_W-1:0] mem [DEPTH];

  func_t             func_r;
  logic [DATA_W-1:0] wr_data_r;
  logic [CNT_W-1:0]  count_r;

  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      rp_r;
  logic [LEVEL_W-1:0] fill_r;
  end_state_t         end_r;
  logic               rdp_r;
  logic               wrp_r;
  logic [CNT_W-1:0]   remaining_r;
  logic [DATA_W-1:0]  rd_q_r;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [DATA_W-1:0]  out_rd_data_r;
  logic               out_data_valid_r;
  logic               out_last_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_can_free_r;

  status_t            single_st;
  logic               write_ok;
  logic               burst;
  end_state_t         end_upd;
  logic               rdp_upd;
  logic               wrp_upd;
  logic [CNT_W-1:0]   cnt_sat;
  logic [CNT_W-1:0]   n_rd;
  logic               rd_issue;
  logic [AW-1:0]      wp_nxt;
  logic [AW-1:0]      rp_nxt;

  assign cnt_sat = (count_r > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : count_r;
  assign n_rd    = (32'(fill_r) < 32'(cnt_sat)) ? CNT_W'(fill_r) : cnt_sat;
  assign rd_issue = cmd.start_rd || cmd.cont_rd;
  assign wp_nxt  = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_nxt  = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;

  always_comb begin
    single_st = ST_OK;
    write_ok  = 1'b0;
    burst     = 1'b0;
    end_upd   = end_r;
    rdp_upd   = rdp_r;
    wrp_upd   = wrp_r;
    unique case (func_r)
      FUNC_WRITE: begin
        if (end_r != END_OPEN || !rdp_r) begin
          single_st = ST_BROKEN;
        end else if (fill_r >= LEVEL_W'(DEPTH)) begin
          single_st = ST_BLOCK;
        end else begin
          write_ok = 1'b1;
        end
      end
      FUNC_READ: begin
        if (end_r == END_RD_CLOSED || end_r == END_CLOSED) begin
          single_st = ST_BROKEN;
        end else if (fill_r == '0) begin
          single_st = (end_r == END_WR_CLOSED || !wrp_r) ? ST_EOF : ST_BLOCK;
        end else if (n_rd != '0) begin
          burst = 1'b1;
        end
      end
      FUNC_CLOSE_RD: begin
        rdp_upd = 1'b0;
        end_upd = (end_r == END_WR_CLOSED) ? END_CLOSED : END_RD_CLOSED;
      end
      FUNC_CLOSE_WR: begin
        wrp_upd = 1'b0;
        end_upd = (end_r == END_RD_CLOSED) ? END_CLOSED : END_WR_CLOSED;
      end
      default: begin
        single_st = ST_OK;
      end
    endcase
  end

  assign sts.burst    = burst;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign sts.rd_last  = (remaining_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.single && write_ok) begin
      mem[wp_r] <= wr_data_r;
    end
    if (rd_issue) begin
      rd_q_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r    <= func_t'(in_func);
      wr_data_r <= in_wr_data;
      count_r   <= in_count;
    end
    if (cmd.start_rd) begin
      remaining_r <= n_rd - 1'b1;
    end else if (cmd.cont_rd) begin
      remaining_r <= remaining_r - 1'b1;
    end
    if (cmd.single) begin
      out_status_r     <= single_st;
      out_rd_data_r    <= '0;
      out_data_valid_r <= 1'b0;
      out_last_r       <= 1'b1;
      out_level_r      <= write_ok ? fill_r + 1'b1 : fill_r;
      out_can_free_r   <= (end_upd == END_CLOSED);
    end else if (cmd.push_byte) begin
      out_status_r     <= ST_OK;
      out_rd_data_r    <= rd_q_r;
      out_data_valid_r <= 1'b1;
      out_last_r       <= (remaining_r == '0);
      out_level_r      <= fill_r;
      out_can_free_r   <= (end_r == END_CLOSED);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      end_r       <= END_OPEN;
      rdp_r       <= 1'b1;
      wrp_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.single) begin
        end_r <= end_upd;
        rdp_r <= rdp_upd;
        wrp_r <= wrp_upd;
        if (write_ok) begin
          wp_r   <= wp_nxt;
          fill_r <= fill_r + 1'b1;
        end
      end else if (rd_issue) begin
        rp_r   <= rp_nxt;
        fill_r <= fill_r - 1'b1;
      end
      if (cmd.single || cmd.push_byte) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_rd_data    = out_rd_data_r;
  assign out_data_valid = out_data_valid_r;
  assign out_last       = out_last_r;
  assign out_level      = out_level_r;
  assign out_can_free   = out_can_free_r;

endmodule

>>> rtl/byte_pipe_fifo_with_close.sv
// Top level of the byte pipe with read and write ends that can be closed.
//
//   Channel  Direction  Handshake          Word
//   in_      input      in_valid/in_stall  func, wr_data, count
//   out_     output     out_valid/out_stall status, rd_data, data_valid, last, level, can_free
//
// A write, a close or a read that returns no byte is latched on acceptance; its word
// is loaded into the output register once that register is free.
// A read of n bytes passes each byte through a read register into the output register.
// A new operation is accepted only once every word of the previous one has been loaded.
// Output stalls hold the output register and pause the read burst in place.
// Reset is synchronous and needs no clearing pass: the store is read only where written.
module byte_pipe_fifo_with_close
  import bpfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [DATA_W-1:0]  in_wr_data,
  input  logic [CNT_W-1:0]   in_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [DATA_W-1:0]  out_rd_data,
  output logic               out_data_valid,
  output logic               out_last,
  output logic [LEVEL_W-1:0] out_level,
  output logic               out_can_free
);

  cmd_t cmd;
  sts_t sts;

  bpfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bpfc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_func),
    .in_wr_data     (in_wr_data),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_rd_data    (out_rd_data),
    .out_data_valid (out_data_valid),
    .out_last       (out_last),
    .out_level      (out_level),
    .out_can_free   (out_can_free)
  );

endmodule

>>> rtl/bpfc_checker.sv
// Port-level assertion checker of the byte pipe and its bind.
`include "byte_pipe_fifo_with_close_assert.svh"

module bpfc_checker
  import bpfc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [DATA_W-1:0]  out_rd_data,
  input logic               out_data_valid,
  input logic               out_last,
  input logic [LEVEL_W-1:0] out_level
);

  `BPFC_ASSERT(a_out_valid_held, out_valid && out_stall |=> out_valid, "output word dropped while stalled")
  `BPFC_ASSERT(a_out_word_held, out_valid && out_stall |=> $stable(out_rd_data) && $stable(out_level), "stalled output word changed")
  `BPFC_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second operation accepted while one is in progress")
  `BPFC_ASSERT(a_no_byte_is_last, out_valid && !out_data_valid |-> out_last && out_rd_data == '0, "word without a byte must be the last and carry zero")
  `BPFC_ASSERT(a_byte_is_ok, out_valid && out_data_valid |-> out_status == ST_OK && out_level < LEVEL_W'(DEPTH), "byte word with a failure status or a full level")

endmodule

bind byte_pipe_fifo_with_close bpfc_checker u_bpfc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_rd_data    (out_rd_data),
  .out_data_valid (out_data_valid),
  .out_last       (out_last),
  .out_level      (out_level)
);
